FILE: rtl/core/midi_note_pair_linker_unit_macros.svh
// Assertion macros for the note pair linker.
// Every property is clocked on clk_i and switched off while rst_ni is low.
`ifndef MIDI_NOTE_PAIR_LINKER_UNIT_MACROS_SVH
`define MIDI_NOTE_PAIR_LINKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MNPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MNPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mnpl_pkg.sv
package mnpl_pkg;

  localparam int PENDING_DEPTH  = 4;
  localparam int POSITION_WIDTH = 16;
  localparam int NUM_CHANNELS   = 16;
  localparam int NUM_KEYS       = 128;

  localparam int CHAN_W   = $clog2(NUM_CHANNELS);
  localparam int KEY_W    = $clog2(NUM_KEYS);
  localparam int SLOT_W   = CHAN_W + KEY_W;
  localparam int FILL_W   = $clog2(PENDING_DEPTH + 1);
  localparam int LVL_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int STORE_DEPTH = (1 << (SLOT_W + LVL_W));

  // Fill counts are packed eight to a row; one valid bit per row.
  localparam int LANE_W   = 3;
  localparam int ROW_SLOTS = (1 << LANE_W);
  localparam int ROW_W    = SLOT_W - LANE_W;
  localparam int ROW_CNT  = (1 << ROW_W);

  localparam int OUT_POS_W = 16;
  localparam int COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } mnpl_op_e;

  typedef struct packed {
    logic                      start;
    mnpl_op_e                  op;
    logic [SLOT_W-1:0]         slot;
    logic [POSITION_WIDTH-1:0] pos;
  } mnpl_cmd_t;

  function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [POSITION_WIDTH-1:0] p);
    return OUT_POS_W'(p);
  endfunction

endpackage

FILE: rtl/core/mnpl_front.sv
module mnpl_front import mnpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_of_track_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  key_number_i,
  input  logic [6:0]  velocity_i,
  input  logic [15:0] event_position_i,
  output logic        cmd_valid_o,
  output mnpl_cmd_t   cmd_o,
  input  logic        cmd_ready_i
);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  mnpl_cmd_t          queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  mnpl_cmd_t          cmd_new;
  logic               push, pop;

  // Classify the event.
  always_comb begin
    cmd_new.start = start_of_track_i;
    cmd_new.slot  = {status_byte_i[CHAN_W-1:0], key_number_i};
    cmd_new.pos   = POSITION_WIDTH'(event_position_i);
    if (status_byte_i[7:4] == CMD_NOTE_ON && velocity_i != 7'd0) begin
      cmd_new.op = OP_PUSH;
    end else if (status_byte_i[7:4] == CMD_NOTE_OFF || status_byte_i[7:4] == CMD_NOTE_ON) begin
      cmd_new.op = OP_POP;
    end else begin
      cmd_new.op = OP_NONE;
    end
  end

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: rtl/core/mnpl_back.sv
module mnpl_back import mnpl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  mnpl_cmd_t            cmd_i,
  output logic                 cmd_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 pair_found_o,
  output logic [OUT_POS_W-1:0] note_on_position_o,
  output logic [OUT_POS_W-1:0] note_off_position_o,
  output logic [COUNT_W-1:0]   pair_count_o,
  output logic                 overflow_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  mnpl_cmd_t                      cmd_q;
  logic [ROW_CNT-1:0]             row_valid_q;
  logic [COUNT_W-1:0]             count_q;
  logic                           found_q, ovf_q;
  logic                           out_valid_q, found_out_q, ovf_out_q;
  logic [OUT_POS_W-1:0]           on_pos_q, off_pos_q;
  logic [COUNT_W-1:0]             count_out_q;

  logic [ROW_SLOTS*FILL_W-1:0]    fill_mem [ROW_CNT];
  logic [ROW_SLOTS*FILL_W-1:0]    fill_rd_q;
  logic [POSITION_WIDTH-1:0]      store_mem [STORE_DEPTH];
  logic [POSITION_WIDTH-1:0]      store_rd_q;

  logic [ROW_W-1:0]               row, head_row;
  logic [LANE_W-1:0]              lane;
  logic [ROW_SLOTS*FILL_W-1:0]    row_cur, row_new;
  logic [FILL_W-1:0]              fill_cur, fill_new;
  logic                           is_push, is_pop, full, empty;
  logic                           do_push, do_pop, fill_we;
  logic [SLOT_W+LVL_W-1:0]        wr_addr, rd_addr;

  assign head_row = cmd_i.slot[SLOT_W-1 -: ROW_W];
  assign row      = cmd_q.slot[SLOT_W-1 -: ROW_W];
  assign lane     = cmd_q.slot[LANE_W-1:0];

  // A row not written since reset or start of track reads as all empty.
  assign row_cur  = row_valid_q[row] ? fill_rd_q : '0;
  assign fill_cur = row_cur[lane*FILL_W +: FILL_W];

  assign is_push = (cmd_q.op == OP_PUSH);
  assign is_pop  = (cmd_q.op == OP_POP);
  assign full    = (fill_cur >= FILL_W'(PENDING_DEPTH));
  assign empty   = (fill_cur == '0);
  assign do_push = (state_q == ST_FILL) && is_push && !full;
  assign do_pop  = (state_q == ST_FILL) && is_pop && !empty;
  assign fill_we = do_push || do_pop;

  always_comb begin
    fill_new = do_push ? fill_cur + 1'b1 : fill_cur - 1'b1;
    row_new  = row_cur;
    row_new[lane*FILL_W +: FILL_W] = fill_new;
  end

  assign wr_addr = {cmd_q.slot, LVL_W'(fill_cur)};
  assign rd_addr = {cmd_q.slot, LVL_W'(fill_cur - 1'b1)};

  assign cmd_ready_o = (state_q == ST_IDLE);

  // Memories: fill rows and pending positions.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      fill_rd_q <= fill_mem[head_row];
    end
    if (fill_we) begin
      fill_mem[row] <= row_new;
    end
    if (do_push) begin
      store_mem[wr_addr] <= cmd_q.pos;
    end
    if (do_pop) begin
      store_rd_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      row_valid_q <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_out_q <= 1'b0;
      ovf_out_q   <= 1'b0;
      on_pos_q    <= '0;
      off_pos_q   <= '0;
      count_out_q <= '0;
    end else begin
      // Drop the taken result unless a new one replaces it below.
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (cmd_i.start) begin
              row_valid_q <= '0;
              count_q     <= '0;
            end
            state_q <= ST_FILL;
          end
        end
        ST_FILL: begin
          found_q <= do_pop;
          ovf_q   <= is_push && full;
          if (fill_we) begin
            row_valid_q[row] <= 1'b1;
          end
          if (do_pop && count_q != COUNT_MAX) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            found_out_q <= found_q;
            ovf_out_q   <= ovf_q;
            on_pos_q    <= found_q ? to_out_pos(store_rd_q) : '0;
            off_pos_q   <= found_q ? to_out_pos(cmd_q.pos) : '0;
            count_out_q <= count_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pair_found_o        = found_out_q;
  assign note_on_position_o  = on_pos_q;
  assign note_off_position_o = off_pos_q;
  assign pair_count_o        = count_out_q;
  assign overflow_o          = ovf_out_q;

endmodule

FILE: rtl/core/midi_note_pair_linker_unit.sv
// MIDI note pair linker.
// Input channel (in_valid_i / in_ready_o): one MIDI event per item, in track
// order: start-of-track flag, status byte, key, velocity and event position.
// Output channel (out_valid_o / out_ready_i): exactly one result item per
// input item, in the same order: pair flag, note-on and note-off positions,
// running pair count and the overflow flag for a dropped note-on.
// An accepted item goes through the queue, then the sequencer's idle, fill
// and emit states into the output register. The sequencer ends each item,
// with its read-modify-write of the fill-count row memory (registered read,
// update, write back), before it takes the next one from the queue.
// A two-entry queue between the classifier and the stack sequencer lets the
// input side keep accepting while the sequencer works or the output stalls.
// When the receiver stalls, the result holds in the output register, the
// sequencer waits with its next result and the queue fills; in_ready_o then
// drops until space frees up.
// Reset empties every stack and zeroes the pair count at once: each row of
// eight fill counts carries a valid bit, and reset clears the valid bits, so
// no clearing pass runs and items are taken from the first cycle.
module midi_note_pair_linker_unit import mnpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_of_track_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  key_number_i,
  input  logic [6:0]  velocity_i,
  input  logic [15:0] event_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pair_found_o,
  output logic [15:0] note_on_position_o,
  output logic [15:0] note_off_position_o,
  output logic [15:0] pair_count_o,
  output logic        overflow_o
);

  // Classified item travelling from front to back.
  mnpl_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_ready;

  // Front: classify note-on, note-off and other events, then queue them.
  mnpl_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_of_track_i (start_of_track_i),
    .status_byte_i    (status_byte_i),
    .key_number_i     (key_number_i),
    .velocity_i       (velocity_i),
    .event_position_i (event_position_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_ready_i      (cmd_ready)
  );

  // Back: push or pop the per-channel, per-key stack, count pairs, hold the result.
  mnpl_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_valid_i         (cmd_valid),
    .cmd_i               (cmd),
    .cmd_ready_o         (cmd_ready),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_found_o        (pair_found_o),
    .note_on_position_o  (note_on_position_o),
    .note_off_position_o (note_off_position_o),
    .pair_count_o        (pair_count_o),
    .overflow_o          (overflow_o)
  );

endmodule

FILE: rtl/core/mnpl_checker.sv
`include "midi_note_pair_linker_unit_macros.svh"

module mnpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        start_of_track_i,
  input logic [7:0]  status_byte_i,
  input logic [6:0]  key_number_i,
  input logic [6:0]  velocity_i,
  input logic [15:0] event_position_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        pair_found_o,
  input logic [15:0] note_on_position_o,
  input logic [15:0] note_off_position_o,
  input logic [15:0] pair_count_o,
  input logic        overflow_o
);

  // Hold a waiting input item.
  `MNPL_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_o,
    in_valid_i && $stable({start_of_track_i, status_byte_i, key_number_i, velocity_i,
    event_position_i}), "waiting input item changed")

  // Hold a stalled result.
  `MNPL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(pair_count_o) && $stable(pair_found_o),
    "stalled result changed")

  // A matched pair and a dropped note-on never come from the same item.
  `MNPL_ASSERT_IMP(a_found_no_ovf, out_valid_o && pair_found_o, !overflow_o,
    "pair and overflow in one result")

  // Without a match both positions read zero.
  `MNPL_ASSERT_IMP(a_nomatch_zero, out_valid_o && !pair_found_o,
    note_on_position_o == 16'd0 && note_off_position_o == 16'd0,
    "positions set without a pair")

  // A match always leaves a nonzero pair count.
  `MNPL_ASSERT_IMP(a_found_count, out_valid_o && pair_found_o, pair_count_o != 16'd0,
    "pair reported with zero count")

endmodule

bind midi_note_pair_linker_unit mnpl_checker u_mnpl_checker (.*);

FILE: tb/midi_note_pair_linker_unit_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the MIDI note pair linker.
// A small scoreboard keeps its own per-channel, per-key stacks of pending
// note-on positions and the running pair count. It works out the result
// that every accepted item should give, queues it, and compares each result
// item that the block hands out against the oldest entry in that queue.
module midi_note_pair_linker_unit_tb;
  import mnpl_pkg::*;

  localparam int NUM_SLOTS = NUM_CHANNELS * NUM_KEYS;
  localparam int HOT_SLOTS = 6;
  localparam int PHASE_ITEMS = 425;

  // Commands the block must leave alone.
  localparam logic [3:0] CMD_DATA_LOW      = 4'h0;
  localparam logic [3:0] CMD_DATA_HIGH     = 4'h7;
  localparam logic [3:0] CMD_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] CMD_SYSTEM        = 4'hF;

  typedef struct packed {
    logic               pair_found;
    logic [OUT_POS_W-1:0] note_on_position;
    logic [OUT_POS_W-1:0] note_off_position;
    logic [COUNT_W-1:0]   pair_count;
    logic               overflow;
  } link_result_t;

  // Tracks pending note-ons and holds the results still owed by the block.
  class note_link_book;
    logic [POSITION_WIDTH-1:0] stack_pos [NUM_SLOTS][PENDING_DEPTH];
    int unsigned               stack_fill [NUM_SLOTS];
    logic [COUNT_W-1:0]        pairs_linked;
    link_result_t              awaited_links [$];
    int unsigned errors, results_seen, pairs_made, drops, lone_offs, ignored;
    int unsigned track_starts;

    function new();
      foreach (stack_fill[i]) stack_fill[i] = 0;
      pairs_linked = '0;
    endfunction

    function void log_event(logic sot, logic [7:0] status, logic [6:0] key,
                            logic [6:0] vel, logic [15:0] pos);
      logic [SLOT_W-1:0] slot;
      mnpl_op_e          op;
      link_result_t      r;
      slot = {status[3:0], key};
      if (status[7:4] == CMD_NOTE_ON && vel != '0) op = OP_PUSH;
      else if (status[7:4] == CMD_NOTE_OFF || status[7:4] == CMD_NOTE_ON) op = OP_POP;
      else op = OP_NONE;
      // Start of track empties every stack before the event itself is handled.
      if (sot) begin
        foreach (stack_fill[i]) stack_fill[i] = 0;
        pairs_linked = '0;
        track_starts++;
      end
      r = '0;
      case (op)
        OP_PUSH: begin
          if (stack_fill[slot] >= PENDING_DEPTH) begin
            r.overflow = 1'b1;
            drops++;
          end else begin
            stack_pos[slot][stack_fill[slot]] = pos[POSITION_WIDTH-1:0];
            stack_fill[slot]++;
          end
        end
        OP_POP: begin
          if (stack_fill[slot] == 0) begin
            lone_offs++;
          end else begin
            stack_fill[slot]--;
            r.pair_found        = 1'b1;
            r.note_on_position  = OUT_POS_W'(stack_pos[slot][stack_fill[slot]]);
            r.note_off_position = pos;
            if (pairs_linked != COUNT_MAX) pairs_linked++;
            pairs_made++;
          end
        end
        default: begin
          ignored++;
        end
      endcase
      r.pair_count = pairs_linked;
      awaited_links.insert(awaited_links.size(), r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_link(link_result_t got);
      link_result_t want;
      if (awaited_links.size() == 0) begin
        $error("result item with no event waiting for it: %h", got);
        errors++;
        return;
      end
      want = awaited_links.pop_front();
      results_seen++;
      compare_field("pair_found", 16'(want.pair_found), 16'(got.pair_found));
      compare_field("note_on_position", want.note_on_position, got.note_on_position);
      compare_field("note_off_position", want.note_off_position, got.note_off_position);
      compare_field("pair_count", want.pair_count, got.pair_count);
      compare_field("overflow", 16'(want.overflow), 16'(got.overflow));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        start_of_track_i = 1'b0;
  logic [7:0]  status_byte_i = '0;
  logic [6:0]  key_number_i = '0;
  logic [6:0]  velocity_i = '0;
  logic [15:0] event_position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        pair_found_o;
  logic [15:0] note_on_position_o;
  logic [15:0] note_off_position_o;
  logic [15:0] pair_count_o;
  logic        overflow_o;

  note_link_book     book = new();
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic [SLOT_W-1:0] hot_slots [HOT_SLOTS];
  logic [15:0]       track_pos = '0;

  midi_note_pair_linker_unit u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .start_of_track_i    (start_of_track_i),
    .status_byte_i       (status_byte_i),
    .key_number_i        (key_number_i),
    .velocity_i          (velocity_i),
    .event_position_i    (event_position_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_found_o        (pair_found_o),
    .note_on_position_o  (note_on_position_o),
    .note_off_position_o (note_off_position_o),
    .pair_count_o        (pair_count_o),
    .overflow_o          (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one item, after a random number of idle cycles, and hold it until
  // the block takes it. Return at the accepting edge so that a following
  // call can raise the next item on that very edge without a gap.
  task automatic send_event(input logic sot, input logic [7:0] status,
                            input logic [6:0] key, input logic [6:0] vel,
                            input logic [15:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    start_of_track_i <= sot;
    status_byte_i    <= status;
    key_number_i     <= key;
    velocity_i       <= vel;
    event_position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.log_event(sot, status, key, vel, pos);
  endtask

  // Mostly well-formed traffic on a handful of busy keys so that stacks fill,
  // overflow and drain; the rest spreads over every channel and key, with
  // arbitrary status bytes as noise and the odd start of track.
  task automatic send_random_event();
    logic [3:0]  chan;
    logic [6:0]  key;
    logic [7:0]  status;
    logic [6:0]  vel;
    logic [15:0] pos;
    int          roll;
    if ($urandom_range(99) < 70) begin
      {chan, key} = hot_slots[$urandom_range(HOT_SLOTS - 1)];
    end else begin
      {chan, key} = SLOT_W'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 45) begin
      status = {CMD_NOTE_ON, chan};
      vel    = 7'($urandom_range(1, 127));
    end else if (roll < 55) begin
      status = {CMD_NOTE_ON, chan};
      vel    = '0;
    end else if (roll < 85) begin
      status = {CMD_NOTE_OFF, chan};
      vel    = 7'($urandom);
    end else begin
      status = 8'($urandom);
      vel    = 7'($urandom);
    end
    track_pos += 16'($urandom_range(1, 3));
    pos = ($urandom_range(3) == 0) ? 16'($urandom) : track_pos;
    send_event($urandom_range(63) == 0, status, key, vel, pos);
  endtask

  // Check each result item at the edge that takes it, then pick the ready
  // level for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_link({pair_found_o, note_on_position_o, note_off_position_o,
                       pair_count_o, overflow_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int idle_plan  [4];
    int stall_plan [4];
    idle_plan  = '{0, 74, 0, 29};
    stall_plan = '{0, 0, 74, 29};
    hot_slots[0] = '0;
    hot_slots[1] = '1;
    for (int i = 2; i < HOT_SLOTS; i++) hot_slots[i] = SLOT_W'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a note-off straight after reset finds nothing to pair with.
    send_event(1'b1, {CMD_NOTE_OFF, 4'h0}, 7'd0, 7'd0, 16'h0000);
    // Fill the top channel and key to the stack depth, then one more to drop.
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd127, 16'hFFFF);
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd1, 16'h0001);
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd64, 16'h0002);
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd100, 16'h0003);
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd127, 16'h0004);
    // Drain newest first, using both note-off forms, and one pop too many.
    send_event(1'b0, {CMD_NOTE_OFF, 4'hF}, 7'd127, 7'd0, 16'h0010);
    send_event(1'b0, {CMD_NOTE_ON, 4'hF}, 7'd127, 7'd0, 16'h0011);
    send_event(1'b0, {CMD_NOTE_OFF, 4'hF}, 7'd127, 7'd127, 16'h0012);
    send_event(1'b0, {CMD_NOTE_OFF, 4'hF}, 7'd127, 7'd64, 16'hFFFE);
    send_event(1'b0, {CMD_NOTE_OFF, 4'hF}, 7'd127, 7'd1, 16'h0013);
    // Hold notes on two other slots across commands that must not touch them.
    send_event(1'b0, {CMD_NOTE_ON, 4'h0}, 7'd0, 7'd1, 16'h1234);
    send_event(1'b0, {CMD_NOTE_ON, 4'h5}, 7'd64, 7'd64, 16'h8000);
    send_event(1'b0, {CMD_DATA_LOW, 4'h0}, 7'd0, 7'd0, 16'h0020);
    send_event(1'b0, {CMD_POLY_PRESSURE, 4'h0}, 7'd0, 7'd127, 16'h0021);
    send_event(1'b0, {CMD_SYSTEM, 4'hF}, 7'd127, 7'd127, 16'h0022);
    send_event(1'b0, {CMD_DATA_HIGH, 4'hF}, 7'd0, 7'd0, 16'h0023);
    // Same key on another channel is a different stack.
    send_event(1'b0, {CMD_NOTE_OFF, 4'h1}, 7'd0, 7'd0, 16'h0024);
    send_event(1'b0, {CMD_NOTE_OFF, 4'h0}, 7'd0, 7'd0, 16'h0025);
    // Start of track drops the held note and the count.
    send_event(1'b1, {CMD_NOTE_OFF, 4'h5}, 7'd64, 7'd0, 16'h0030);
    send_event(1'b1, {CMD_NOTE_ON, 4'h3}, 7'd10, 7'd5, 16'h0031);
    send_event(1'b0, {CMD_NOTE_OFF, 4'h3}, 7'd10, 7'd5, 16'h0032);

    // Random traffic through each idling mix in turn.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (PHASE_ITEMS) send_random_event();
    end
    in_valid_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Drain the owed results, then allow a few cycles for anything stray.
    while (book.awaited_links.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Checked %0d results: %0d pairs linked, %0d note-ons dropped on full stacks,",
             book.results_seen, book.pairs_made, book.drops);
    $display("%0d unmatched note-offs, %0d other events, %0d track starts.",
             book.lone_offs, book.ignored, book.track_starts);
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mnpl_pkg.sv
rtl/core/mnpl_front.sv
rtl/core/mnpl_back.sv
rtl/core/midi_note_pair_linker_unit.sv
rtl/core/mnpl_checker.sv
tb/midi_note_pair_linker_unit_tb.sv
